FILE: rtl/fpr_pkg.sv
// Package for the framed packet receiver: shared constants, codes and types.
// No dependencies; every other file refers to it by scoped names.
package fpr_pkg;

  localparam int MAX_PAYLOAD = 32;                 // payload store depth, 2..32
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int QDEPTH      = 2;                  // frame descriptor queue depth
  localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [7:0] START_RESET = 8'hAA;

  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_BAD   = 2'd2;

  // One finished frame, handed from the parser to the result sequencer.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  frame_type;
    logic [7:0]  payload_length;
    logic [15:0] good_count;
    logic [15:0] bad_count;
  } desc_t;

  // Write port of the payload store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

endpackage

FILE: rtl/framed_packet_receiver.sv
// Top level of the framed packet receiver: config register, parser, queue, sequencer.
// Depends on fpr_pkg, fpr_front, fpr_queue and fpr_back.
//
// The receiver takes one serial byte per item (in_tuser = 0) or a flush (in_tuser = 1),
// hunts for the start byte (cfg register, reset 0xAA), then collects type, length,
// payload and an XOR checksum over type, length and payload. A good frame gives one
// result per payload byte (kind 0, last on the final one) or one "good empty" result
// (kind 1); a bad checksum or a length above MAX_PAYLOAD (32) gives one "bad frame"
// result (kind 2) after the whole declared length and checksum are consumed. The
// parser takes one item per cycle; it holds in_tready low only on a payload byte that
// must enter the store while an earlier frame is still queued or being read back, and
// on a checksum byte while the two-entry frame queue is full. Within a payload frame,
// results leave at one per cycle while out_tready is high; before its first result the
// sequencer moves from idle to its emit state while the store's registered read port
// fetches entry 0. The store holds one frame, so the payload of the next frame is
// taken only once that readback ends. Good and bad counters saturate at 65535.
module framed_packet_receiver (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write: start byte
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] op
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [7:0] frame_type, [15:8] payload_length,
                                  // [23:16] data_byte, [28:24] byte_index,
                                  // [44:29] good_count, [60:45] bad_count, [63:61] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last
);

  logic [7:0]         start_r;
  fpr_pkg::desc_t     push_desc, head_desc;
  fpr_pkg::store_wr_t store_wr;
  logic               q_push, q_pop, q_full, q_empty;
  logic               back_busy;
  logic               store_free;
  logic [7:0]         o_type, o_len, o_data;
  logic [4:0]         o_index;
  logic [15:0]        o_good, o_bad;

  // Configuration is always taken; the user must write it only while the block is idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= fpr_pkg::START_RESET;
    end else if (cfg_valid) begin
      start_r <= cfg_data;
    end
  end

  // Release the store only once every earlier frame has been read back.
  assign store_free = q_empty && !back_busy;

  fpr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_byte (start_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_byte    (in_tdata),
    .store_free (store_free),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_desc     (push_desc),
    .store_wr   (store_wr)
  );

  fpr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .head_desc (head_desc),
    .full      (q_full),
    .empty     (q_empty)
  );

  fpr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .store_wr  (store_wr),
    .q_empty   (q_empty),
    .q_head    (head_desc),
    .q_pop     (q_pop),
    .busy      (back_busy),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_type  (o_type),
    .out_len   (o_len),
    .out_data  (o_data),
    .out_index (o_index),
    .out_last  (out_tlast),
    .out_good  (o_good),
    .out_bad   (o_bad)
  );

  // Pack result fields, first field in the lowest bits.
  assign out_tdata = {3'b000, o_bad, o_good, o_index, o_data, o_len, o_type};

  // A finished frame is never pushed into a full queue.
  assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("frame descriptor pushed into full queue");

  // Payload store writes happen only with no frame pending readback.
  assert property (@(posedge clk) disable iff (!rst_n)
    store_wr.en |-> (q_empty && !back_busy))
    else $error("payload store overwritten while a frame is pending");

  // Kind code is one of the three defined results.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser == fpr_pkg::KIND_DATA) || (out_tuser == fpr_pkg::KIND_EMPTY) ||
                    (out_tuser == fpr_pkg::KIND_BAD)))
    else $error("undefined result kind");

endmodule

FILE: rtl/fpr_front.sv
// Frame parser: hunts for the start byte, collects type, length, payload and checksum.
// Depends on fpr_pkg; writes the payload store and pushes frame descriptors.
module fpr_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         start_byte,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [7:0]         in_byte,
  input  logic               store_free,
  input  logic               q_full,
  output logic               q_push,
  output fpr_pkg::desc_t     q_desc,
  output fpr_pkg::store_wr_t store_wr
);

  typedef enum logic [4:0] {
    PH_HUNT  = 5'b00001,
    PH_TYPE  = 5'b00010,
    PH_LEN   = 5'b00100,
    PH_DATA  = 5'b01000,
    PH_CHECK = 5'b10000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [15:0] good_r, good_nxt;
  logic [15:0] bad_r, bad_nxt;
  logic        stores_byte;
  logic        acc;
  logic        ok;

  // A payload byte that lands in the store waits until the store is released.
  assign stores_byte = (phase_r == PH_DATA) && (cnt_r < 8'(fpr_pkg::MAX_PAYLOAD));
  assign in_ready    = !((stores_byte && !store_free) || ((phase_r == PH_CHECK) && q_full));
  assign acc         = in_valid && in_ready;
  assign ok          = (len_r <= 8'(fpr_pkg::MAX_PAYLOAD)) && (in_byte == xor_r);

  always_comb begin
    phase_nxt = phase_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    xor_nxt   = xor_r;
    good_nxt  = good_r;
    bad_nxt   = bad_r;
    q_push    = 1'b0;
    store_wr.en   = 1'b0;
    store_wr.addr = cnt_r[fpr_pkg::ADDR_W-1:0];
    store_wr.data = in_byte;
    if (acc) begin
      if (in_op == fpr_pkg::OP_FLUSH) begin
        phase_nxt = PH_HUNT;
      end else begin
        unique case (phase_r)
          PH_HUNT: begin
            if (in_byte == start_byte) phase_nxt = PH_TYPE;
          end
          PH_TYPE: begin
            type_nxt  = in_byte;
            xor_nxt   = in_byte;
            phase_nxt = PH_LEN;
          end
          PH_LEN: begin
            len_nxt   = in_byte;
            xor_nxt   = xor_r ^ in_byte;
            cnt_nxt   = 8'd0;
            phase_nxt = (in_byte == 8'd0) ? PH_CHECK : PH_DATA;
          end
          PH_DATA: begin
            store_wr.en = stores_byte;
            xor_nxt     = xor_r ^ in_byte;
            cnt_nxt     = cnt_r + 8'd1;
            if (cnt_nxt == len_r) phase_nxt = PH_CHECK;
          end
          PH_CHECK: begin
            phase_nxt = PH_HUNT;
            q_push    = 1'b1;
            if (!ok) begin
              if (bad_r != 16'hFFFF) bad_nxt = bad_r + 16'd1;
            end else begin
              if (good_r != 16'hFFFF) good_nxt = good_r + 16'd1;
            end
          end
          default: phase_nxt = PH_HUNT;
        endcase
      end
    end
  end

  always_comb begin
    q_desc.frame_type     = type_r;
    q_desc.payload_length = len_r;
    q_desc.good_count     = good_nxt;
    q_desc.bad_count      = bad_nxt;
    if (!ok)                 q_desc.kind = fpr_pkg::KIND_BAD;
    else if (len_r == 8'd0)  q_desc.kind = fpr_pkg::KIND_EMPTY;
    else                     q_desc.kind = fpr_pkg::KIND_DATA;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      type_r  <= 8'd0;
      len_r   <= 8'd0;
      cnt_r   <= 8'd0;
      xor_r   <= 8'd0;
      good_r  <= 16'd0;
      bad_r   <= 16'd0;
    end else begin
      phase_r <= phase_nxt;
      type_r  <= type_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      xor_r   <= xor_nxt;
      good_r  <= good_nxt;
      bad_r   <= bad_nxt;
    end
  end

endmodule

FILE: rtl/fpr_queue.sv
// Short descriptor queue between the parser and the result sequencer.
// Depends on fpr_pkg for the descriptor type and depth.
module fpr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fpr_pkg::desc_t push_desc,
  input  logic           pop,
  output fpr_pkg::desc_t head_desc,
  output logic           full,
  output logic           empty
);

  fpr_pkg::desc_t              slot_r [fpr_pkg::QDEPTH];
  logic [fpr_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [fpr_pkg::QCNT_W-1:0] cnt_r;
  logic                        do_push, do_pop;

  assign full      = (cnt_r == fpr_pkg::QCNT_W'(fpr_pkg::QDEPTH));
  assign empty     = (cnt_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_desc = slot_r[rd_ptr_r];

  function automatic logic [fpr_pkg::QPTR_W-1:0] bump(input logic [fpr_pkg::QPTR_W-1:0] p);
    if (p == fpr_pkg::QPTR_W'(fpr_pkg::QDEPTH - 1)) return '0;
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= bump(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

FILE: rtl/fpr_back.sv
// Result sequencer: holds the payload store and turns frame descriptors into results.
// Depends on fpr_pkg; reads descriptors from fpr_queue, drives the output register.
module fpr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  fpr_pkg::store_wr_t store_wr,
  input  logic               q_empty,
  input  fpr_pkg::desc_t     q_head,
  output logic               q_pop,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_type,
  output logic [7:0]         out_len,
  output logic [7:0]         out_data,
  output logic [4:0]         out_index,
  output logic               out_last,
  output logic [15:0]        out_good,
  output logic [15:0]        out_bad
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } st_t;

  logic [7:0]                  mem [fpr_pkg::MAX_PAYLOAD];
  logic [7:0]                  rd_data_r;
  st_t                         st_r, st_nxt;
  logic [fpr_pkg::ADDR_W-1:0] idx_r, idx_nxt;
  fpr_pkg::desc_t              desc_r, desc_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        load;
  logic [1:0]                  kind_nxt;
  logic [7:0]                  data_nxt;
  logic [4:0]                  index_nxt;
  logic                        last_nxt;
  logic [15:0]                 good_nxt, bad_nxt;
  logic [7:0]                  type_nxt, len_nxt;
  logic                        out_free;
  logic                        final_byte;

  assign out_free   = !out_valid_r || out_ready;
  assign final_byte = ((8'(idx_r) + 8'd1) == desc_r.payload_length);
  assign busy       = (st_r != ST_IDLE);

  always_comb begin
    st_nxt        = st_r;
    idx_nxt       = '0;
    desc_nxt      = desc_r;
    q_pop         = 1'b0;
    load          = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt      = q_head.kind;
    type_nxt      = q_head.frame_type;
    len_nxt       = q_head.payload_length;
    good_nxt      = q_head.good_count;
    bad_nxt       = q_head.bad_count;
    data_nxt      = 8'd0;
    index_nxt     = 5'd0;
    last_nxt      = 1'b1;
    unique case (st_r)
      ST_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop    = 1'b1;
          desc_nxt = q_head;
          if (q_head.kind == fpr_pkg::KIND_DATA) begin
            st_nxt = ST_EMIT;           // store read of entry 0 starts now
          end else begin
            load          = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        idx_nxt   = idx_r;
        kind_nxt  = desc_r.kind;
        type_nxt  = desc_r.frame_type;
        len_nxt   = desc_r.payload_length;
        good_nxt  = desc_r.good_count;
        bad_nxt   = desc_r.bad_count;
        data_nxt  = rd_data_r;
        index_nxt = 5'(idx_r);
        last_nxt  = final_byte;
        if (out_free) begin
          load          = 1'b1;
          out_valid_nxt = 1'b1;
          if (final_byte) begin
            st_nxt  = ST_IDLE;
            idx_nxt = '0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Payload store: one write port from the parser, one registered read port.
  always_ff @(posedge clk) begin
    if (store_wr.en) mem[store_wr.addr] <= store_wr.data;
    rd_data_r <= mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
    idx_r  <= idx_nxt;
    if (load) begin
      out_kind  <= kind_nxt;
      out_type  <= type_nxt;
      out_len   <= len_nxt;
      out_data  <= data_nxt;
      out_index <= index_nxt;
      out_last  <= last_nxt;
      out_good  <= good_nxt;
      out_bad   <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // Payload results never index past the frame length.
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EMIT) |-> ((8'(idx_r) + 8'd1) <= desc_r.payload_length))
    else $error("payload index beyond frame length");

  // A payload frame is only sequenced when its length fits the store.
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (q_head.kind == fpr_pkg::KIND_DATA)) |->
      ((q_head.payload_length != 8'd0) &&
       (q_head.payload_length <= 8'(fpr_pkg::MAX_PAYLOAD))))
    else $error("payload frame with bad length reached the sequencer");

  // The store is never written while a frame is being read back.
  assert property (@(posedge clk) disable iff (!rst_n)
    store_wr.en |-> (st_r == ST_IDLE))
    else $error("payload store written during readback");

endmodule

FILE: test/framed_packet_receiver_tb.sv
// Self-checking testbench for framed_packet_receiver: streams serial bytes and flushes,
// predicts every result item with a local deframer and compares them field by field.
// Depends on fpr_pkg and the framed_packet_receiver RTL.
`timescale 1ns / 1ps

module framed_packet_receiver_tb;

  localparam int CYCLE_LIMIT = 100000;
  localparam int TAIL_CYCLES = 40;
  localparam int PHASE_ITEMS = 40;
  localparam int MAXP        = fpr_pkg::MAX_PAYLOAD;

  // Parser states of the local deframer
  typedef enum logic [2:0] {HUNT, GET_TYPE, GET_LEN, GET_DATA, GET_CHECK} parse_state_t;

  // One input item: op code and received byte
  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } link_item_t;

  // One result item as the block should deliver it
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  frame_type;
    logic [7:0]  payload_length;
    logic [7:0]  data_byte;
    logic [4:0]  byte_index;
    logic        last;
    logic [15:0] good_count;
    logic [15:0] bad_count;
  } frame_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data   = 8'h00;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;   // [7:0] rx_byte
  logic        in_tuser   = 1'b0;    // [0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;            // frame_type, payload_length, data_byte, byte_index,
                                     // good_count, bad_count, zero pad
  logic [1:0]  out_tuser;            // [1:0] kind
  logic        out_tlast;

  framed_packet_receiver u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stimulus and scoreboard storage
  link_item_t    link_items[$];       // items still to be driven
  frame_result_t awaited_results[$];  // predicted result items, oldest first
  link_item_t    next_item;
  int            mismatches  = 0;
  int            cycle_count = 0;
  int            in_gap      = 0;
  int            out_stall   = 0;
  logic          in_fire     = 1'b0;
  logic          steady      = 1'b0;  // set for the closing phase: no idling at all

  // Deframer state, mirrors the block
  logic [7:0]    start_reg = fpr_pkg::START_RESET;
  parse_state_t  parse_state = HUNT;
  logic [7:0]    held_type   = 8'h00;
  logic [7:0]    held_len    = 8'h00;
  logic [7:0]    byte_cnt    = 8'h00;
  logic [7:0]    run_xor     = 8'h00;
  logic [7:0]    payload_copy [MAXP];
  logic [15:0]   good_frames = 16'h0000;
  logic [15:0]   bad_frames  = 16'h0000;

  // Queue one result item built from the held frame header
  task automatic push_result(input logic [1:0] kind, input logic [7:0] data,
                             input logic [4:0] index, input logic last);
    frame_result_t r;
    r.kind           = kind;
    r.frame_type     = held_type;
    r.payload_length = held_len;
    r.data_byte      = data;
    r.byte_index     = index;
    r.last           = last;
    r.good_count     = good_frames;
    r.bad_count      = bad_frames;
    awaited_results.push_back(r);
  endtask

  // Advance the deframer by one accepted item and queue the results it causes
  task automatic deframe_item(input logic op, input logic [7:0] b);
    logic ok;
    if (op == fpr_pkg::OP_FLUSH) begin
      parse_state = HUNT;
    end else begin
      case (parse_state)
        HUNT: begin
          if (b == start_reg) parse_state = GET_TYPE;
        end
        GET_TYPE: begin
          held_type   = b;
          run_xor     = b;
          parse_state = GET_LEN;
        end
        GET_LEN: begin
          held_len    = b;
          run_xor     = run_xor ^ b;
          byte_cnt    = 8'h00;
          parse_state = (b == 8'h00) ? GET_CHECK : GET_DATA;
        end
        GET_DATA: begin
          // oversize payloads are counted but not stored
          if (byte_cnt < MAXP) payload_copy[byte_cnt[fpr_pkg::ADDR_W-1:0]] = b;
          run_xor  = run_xor ^ b;
          byte_cnt = byte_cnt + 8'd1;
          if (byte_cnt == held_len) parse_state = GET_CHECK;
        end
        GET_CHECK: begin
          parse_state = HUNT;
          ok = (held_len <= MAXP) && (b == run_xor);
          if (!ok) begin
            if (bad_frames != 16'hFFFF) bad_frames = bad_frames + 16'd1;
            push_result(fpr_pkg::KIND_BAD, 8'h00, 5'd0, 1'b1);
          end else begin
            if (good_frames != 16'hFFFF) good_frames = good_frames + 16'd1;
            if (held_len == 8'h00) begin
              push_result(fpr_pkg::KIND_EMPTY, 8'h00, 5'd0, 1'b1);
            end else begin
              for (int k = 0; k < held_len; k++)
                push_result(fpr_pkg::KIND_DATA, payload_copy[k[fpr_pkg::ADDR_W-1:0]],
                            k[4:0], k == held_len - 1);
            end
          end
        end
        default: parse_state = HUNT;
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Sample both handshakes at the rising edge: predict on input items,
  // compare result items against the oldest prediction
  always @(posedge clk) begin
    frame_result_t want;
    in_fire = rst_n && in_tvalid && in_tready;
    if (in_fire) deframe_item(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        $error("result item with none expected: kind %0d tdata 0x%0h", out_tuser, out_tdata);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("kind",           16'(want.kind),           16'(out_tuser));
        check_field("frame_type",     16'(want.frame_type),     16'(out_tdata[7:0]));
        check_field("payload_length", 16'(want.payload_length), 16'(out_tdata[15:8]));
        check_field("data_byte",      16'(want.data_byte),      16'(out_tdata[23:16]));
        check_field("byte_index",     16'(want.byte_index),     16'(out_tdata[28:24]));
        check_field("good_count",     want.good_count,          out_tdata[44:29]);
        check_field("bad_count",      want.bad_count,           out_tdata[60:45]);
        check_field("pad",            16'h0000,                 16'(out_tdata[63:61]));
        check_field("last",           16'(want.last),           16'(out_tlast));
      end
    end
  end

  // Input driver: present the next item once the current one is taken,
  // insert idle bursts between items
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (!steady && link_items.size() > 0 && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 3);
        in_tvalid <= 1'b0;
      end else if (link_items.size() > 0) begin
        next_item = link_items.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= next_item.op;
        in_tdata  <= next_item.rx_byte;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result sink: drop out_tready in random bursts, except in the closing phase
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 6) == 0) begin
      out_stall = $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [7:0] b);
    link_item_t it;
    it.op      = op;
    it.rx_byte = b;
    link_items.push_back(it);
  endtask

  task automatic send_flush();
    send_item(fpr_pkg::OP_FLUSH, 8'($urandom));
  endtask

  // Queue one frame with random payload; optionally spoil the checksum or
  // cut the frame short with a flush
  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] len,
                            input logic corrupt, input logic truncate);
    logic [7:0] frame_bytes[$];
    logic [7:0] chk;
    logic [7:0] b;
    int         cut;
    frame_bytes.push_back(start_reg);
    frame_bytes.push_back(ftype);
    frame_bytes.push_back(len);
    chk = ftype ^ len;
    for (int i = 0; i < len; i++) begin
      b = ($urandom_range(0, 7) == 0) ? start_reg : 8'($urandom);
      frame_bytes.push_back(b);
      chk = chk ^ b;
    end
    if (corrupt) chk = chk ^ 8'($urandom_range(1, 255));
    frame_bytes.push_back(chk);
    cut = truncate ? $urandom_range(1, frame_bytes.size() - 1) : frame_bytes.size();
    for (int i = 0; i < cut; i++) send_item(fpr_pkg::OP_DATA, frame_bytes[i]);
    if (truncate) send_flush();
  endtask

  // Mostly well-formed frames with random content, plus noise, flushes and cut frames
  task automatic random_phase(input int n_items);
    int          base;
    int          pick;
    logic [7:0]  len;
    logic [7:0]  ftype;
    base = link_items.size();
    while (link_items.size() - base < n_items) begin
      pick  = $urandom_range(0, 99);
      len   = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 6))
                                         : 8'($urandom_range(0, MAXP + 4));
      ftype = ($urandom_range(0, 9) == 0) ? start_reg : 8'($urandom);
      if (pick < 8)
        send_item(fpr_pkg::OP_DATA, 8'($urandom));
      else if (pick < 16)
        send_flush();
      else if (pick < 26)
        send_frame(ftype, len, 1'b0, 1'b1);
      else
        send_frame(ftype, len, $urandom_range(0, 4) == 0, 1'b0);
    end
    // leave the parser hunting before the next register write
    send_flush();
  endtask

  // Hold until every item is driven and every result is in, then let the block settle
  task automatic wait_idle();
    while (link_items.size() != 0 || in_tvalid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_start(input logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    start_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, start byte at its reset value
    send_item(fpr_pkg::OP_DATA, 8'h00);          // skipped while hunting
    send_item(fpr_pkg::OP_DATA, 8'hFF);
    send_item(fpr_pkg::OP_FLUSH, 8'h5A);         // flush while already hunting
    // good empty frame, all-zero header
    send_item(fpr_pkg::OP_DATA, 8'hAA);
    send_item(fpr_pkg::OP_DATA, 8'h00);
    send_item(fpr_pkg::OP_DATA, 8'h00);
    send_item(fpr_pkg::OP_DATA, 8'h00);
    // one-byte frame, all-ones type and payload
    send_item(fpr_pkg::OP_DATA, 8'hAA);
    send_item(fpr_pkg::OP_DATA, 8'hFF);
    send_item(fpr_pkg::OP_DATA, 8'h01);
    send_item(fpr_pkg::OP_DATA, 8'hFF);
    send_item(fpr_pkg::OP_DATA, 8'h01);
    // empty frame with a wrong checksum
    send_item(fpr_pkg::OP_DATA, 8'hAA);
    send_item(fpr_pkg::OP_DATA, 8'h12);
    send_item(fpr_pkg::OP_DATA, 8'h00);
    send_item(fpr_pkg::OP_DATA, 8'h13);
    // flush in mid payload; the flush byte equals the start byte and must be ignored
    send_item(fpr_pkg::OP_DATA, 8'hAA);
    send_item(fpr_pkg::OP_DATA, 8'h34);
    send_item(fpr_pkg::OP_DATA, 8'h03);
    send_item(fpr_pkg::OP_DATA, 8'h11);
    send_item(fpr_pkg::OP_FLUSH, 8'hAA);
    // start byte as type and as payload is ordinary frame data
    send_item(fpr_pkg::OP_DATA, 8'hAA);
    send_item(fpr_pkg::OP_DATA, 8'hAA);
    send_item(fpr_pkg::OP_DATA, 8'h01);
    send_item(fpr_pkg::OP_DATA, 8'hAA);
    send_item(fpr_pkg::OP_DATA, 8'h01);
    wait_idle();

    // Start byte at the low extreme; add a full-size frame and one just oversize
    write_start(8'h00);
    send_frame(8'($urandom), 8'(MAXP), 1'b0, 1'b0);
    send_frame(8'($urandom), 8'(MAXP + 1), 1'b0, 1'b0);
    random_phase(PHASE_ITEMS);
    wait_idle();

    write_start(8'hFF);
    random_phase(PHASE_ITEMS);
    wait_idle();

    write_start(8'($urandom_range(1, 254)));
    random_phase(PHASE_ITEMS);
    wait_idle();

    // Closing phase at full rate on both sides
    write_start(fpr_pkg::START_RESET);
    steady = 1'b1;
    random_phase(PHASE_ITEMS);
    wait_idle();

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
